>>> rtl/stsr_pkg.sv
package stsr_pkg;

    // Default table depth and the largest depth the pointer width must cover
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int MAX_TABLE_DEPTH = 65536;

    // Signed search pointer: holds -1 up to MAX_TABLE_DEPTH
    localparam int PTR_W = $clog2(MAX_TABLE_DEPTH + 1) + 1;

    // Fixed field widths of the ports
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 10;
    localparam int COUNT_W = 11;

    // Request opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // One binary search in flight
    typedef struct packed {
        logic signed [PTR_W-1:0] lo;
        logic signed [PTR_W-1:0] hi;
        logic                    hit;
        logic signed [PTR_W-1:0] hit_idx;
    } lane_t;

    // Search token handed from cell to cell
    typedef struct packed {
        logic signed [DATA_W-1:0] key;
        lane_t                    first;
        lane_t                    last;
    } token_t;

endpackage

>>> rtl/stsr_table.sv
module stsr_table #(
    parameter int DEPTH  = stsr_pkg::DEF_TABLE_DEPTH,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [ADDR_W-1:0]                 wr_addr,
    input  logic signed [stsr_pkg::DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]                 rd_addr_a,
    input  logic [ADDR_W-1:0]                 rd_addr_b,
    output logic signed [stsr_pkg::DATA_W-1:0] rd_data_a,
    output logic signed [stsr_pkg::DATA_W-1:0] rd_data_b
);
    import stsr_pkg::*;

    logic signed [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

>>> rtl/stsr_cell.sv
module stsr_cell #(
    parameter int ADDR_W = $clog2(stsr_pkg::DEF_TABLE_DEPTH)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  stsr_pkg::token_t                   in_tok,
    input  logic [ADDR_W-1:0]                  addr_first_in,
    input  logic [ADDR_W-1:0]                  addr_last_in,
    input  logic signed [stsr_pkg::DATA_W-1:0] rdata_first,
    input  logic signed [stsr_pkg::DATA_W-1:0] rdata_last,
    output logic [ADDR_W-1:0]                  addr_first_out,
    output logic [ADDR_W-1:0]                  addr_last_out,
    output logic                               out_valid,
    output stsr_pkg::token_t                   out_tok
);
    import stsr_pkg::*;

    logic   valid_reg;
    logic   phase_reg;
    token_t tok_reg;

    function automatic logic signed [PTR_W-1:0] midpoint(input lane_t ln);
        logic signed [PTR_W-1:0] span;
        span = ln.hi - ln.lo;
        return ln.lo + (span >>> 1);
    endfunction

    // One probe: narrow the window around the entry just read
    function automatic lane_t probe(input lane_t ln, input logic signed [DATA_W-1:0] key,
                                    input logic signed [DATA_W-1:0] v, input logic want_last);
        lane_t                   res;
        logic signed [PTR_W-1:0] mid;
        res = ln;
        mid = midpoint(ln);
        if (ln.lo <= ln.hi)
        begin
            if (v == key)
            begin
                res.hit     = 1'b1;
                res.hit_idx = mid;
                if (want_last)
                begin
                    res.lo = mid + PTR_W'(1);
                end
                else
                begin
                    res.hi = mid - PTR_W'(1);
                end
            end
            else if (key > v)
            begin
                res.lo = mid + PTR_W'(1);
            end
            else
            begin
                res.hi = mid - PTR_W'(1);
            end
        end
        return res;
    endfunction

    // Phase 0 issues the read, phase 1 consumes the data and hands off
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else if (in_valid)
        begin
            valid_reg <= 1'b1;
            phase_reg <= 1'b0;
        end
        else if (valid_reg && phase_reg)
        begin
            valid_reg <= 1'b0;
        end
        else if (valid_reg)
        begin
            phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            tok_reg <= in_tok;
        end
    end

    always_comb
    begin
        if (valid_reg && !phase_reg)
        begin
            addr_first_out = ADDR_W'(midpoint(tok_reg.first));
            addr_last_out  = ADDR_W'(midpoint(tok_reg.last));
        end
        else
        begin
            addr_first_out = addr_first_in;
            addr_last_out  = addr_last_in;
        end
    end

    always_comb
    begin
        out_tok       = tok_reg;
        out_tok.first = probe(tok_reg.first, tok_reg.key, rdata_first, 1'b0);
        out_tok.last  = probe(tok_reg.last, tok_reg.key, rdata_last, 1'b1);
    end

    assign out_valid = valid_reg && phase_reg;

endmodule

>>> rtl/sorted_table_range_search_top.sv
// Sorted table range search.
// Input channel (in_valid / in_stall): op selects a request. A write request
// stores entry_value at entry_index and gives no result; writes at or beyond
// TABLE_DEPTH are dropped. A query request searches the first entry_count
// entries for search_key and gives one result.
// Output channel (out_valid / out_stall): found, first_index, last_index and
// occurrences; all zero when the key is absent.
// Config channel (cfg_valid / cfg_ready): cfg_data sets entry_count, which
// the search clamps to TABLE_DEPTH. cfg_ready is always high.
// Query: a query walks a chain of clog2(TABLE_DEPTH+1) probe cells; each cell
// does one table read and then one compare. in_stall stays high for that
// whole walk. Both searches share the walk through two table read ports.
// Stall: a finished result waits in a one-entry holding register while the
// output is stalled; in_stall stays high until it moves out.
// Reset: clears entry_count and all handshake state; table contents stay
// undefined until written.
module sorted_table_range_search_top #(
    parameter int TABLE_DEPTH = stsr_pkg::DEF_TABLE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                op,
    input  logic [stsr_pkg::IDX_W-1:0]          entry_index,
    input  logic signed [stsr_pkg::DATA_W-1:0]  entry_value,
    input  logic signed [stsr_pkg::DATA_W-1:0]  search_key,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                found,
    output logic [stsr_pkg::IDX_W-1:0]          first_index,
    output logic [stsr_pkg::IDX_W-1:0]          last_index,
    output logic [stsr_pkg::COUNT_W-1:0]        occurrences,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [stsr_pkg::COUNT_W-1:0]        cfg_data
);
    import stsr_pkg::*;

    localparam int ADDR_W    = $clog2(TABLE_DEPTH);
    localparam int NUM_CELLS = $clog2(TABLE_DEPTH + 1);

    logic [COUNT_W-1:0] entry_count_reg;
    logic               busy_reg;
    logic               pend_valid_reg;
    logic               out_valid_reg;

    logic               pend_found_reg;
    logic [IDX_W-1:0]   pend_first_reg;
    logic [IDX_W-1:0]   pend_last_reg;
    logic [COUNT_W-1:0] pend_occ_reg;
    logic               out_found_reg;
    logic [IDX_W-1:0]   out_first_reg;
    logic [IDX_W-1:0]   out_last_reg;
    logic [COUNT_W-1:0] out_occ_reg;

    logic               in_acc;
    logic               start;
    logic               wr_en;
    logic               out_take;
    logic               done;
    logic               out_free;

    logic signed [PTR_W-1:0]  n_ptr;
    token_t                   start_tok;
    logic signed [DATA_W-1:0] rdata_first;
    logic signed [DATA_W-1:0] rdata_last;

    logic                     cell_valid [NUM_CELLS+1];
    token_t                   cell_tok   [NUM_CELLS+1];
    logic [ADDR_W-1:0]        addr_first [NUM_CELLS+1];
    logic [ADDR_W-1:0]        addr_last  [NUM_CELLS+1];

    logic                     res_found;
    logic [IDX_W-1:0]         res_first;
    logic [IDX_W-1:0]         res_last;
    logic [COUNT_W-1:0]       res_occ;
    logic signed [PTR_W-1:0]  res_span;
    lane_t                    end_first;
    lane_t                    end_last;

    // Hold off new requests while a query walks the chain or a result waits
    assign in_stall  = busy_reg || pend_valid_reg;
    assign in_acc    = in_valid && !in_stall;
    assign start     = in_acc && (op == OP_QUERY);
    assign wr_en     = in_acc && (op == OP_WRITE)
                       && (32'(entry_index) < 32'(TABLE_DEPTH));
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            entry_count_reg <= cfg_data;
        end
    end

    // Clamp the search window to the table depth
    always_comb
    begin
        if (32'(entry_count_reg) > 32'(TABLE_DEPTH))
        begin
            n_ptr = PTR_W'(TABLE_DEPTH);
        end
        else
        begin
            n_ptr = PTR_W'(entry_count_reg);
        end
    end

    always_comb
    begin
        start_tok.key           = search_key;
        start_tok.first.lo      = '0;
        start_tok.first.hi      = n_ptr - PTR_W'(1);
        start_tok.first.hit     = 1'b0;
        start_tok.first.hit_idx = '0;
        start_tok.last          = start_tok.first;
    end

    stsr_table #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (ADDR_W'(entry_index)),
        .wr_data   (entry_value),
        .rd_addr_a (addr_first[NUM_CELLS]),
        .rd_addr_b (addr_last[NUM_CELLS]),
        .rd_data_a (rdata_first),
        .rd_data_b (rdata_last)
    );

    // Probe chain: the active cell drives its midpoints onto the address chain
    assign cell_valid[0] = start;
    assign cell_tok[0]   = start_tok;
    assign addr_first[0] = '0;
    assign addr_last[0]  = '0;

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        stsr_cell #(
            .ADDR_W (ADDR_W)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .in_valid       (cell_valid[i]),
            .in_tok         (cell_tok[i]),
            .addr_first_in  (addr_first[i]),
            .addr_last_in   (addr_last[i]),
            .rdata_first    (rdata_first),
            .rdata_last     (rdata_last),
            .addr_first_out (addr_first[i+1]),
            .addr_last_out  (addr_last[i+1]),
            .out_valid      (cell_valid[i+1]),
            .out_tok        (cell_tok[i+1])
        );
    end

    // Merge the two searches into one result
    assign done      = cell_valid[NUM_CELLS];
    assign end_first = cell_tok[NUM_CELLS].first;
    assign end_last  = cell_tok[NUM_CELLS].last;
    assign res_span  = end_last.hit_idx - end_first.hit_idx + PTR_W'(1);

    always_comb
    begin
        res_found = end_first.hit && end_last.hit && (end_last.hit_idx >= end_first.hit_idx);
        if (res_found)
        begin
            res_first = end_first.hit_idx[IDX_W-1:0];
            res_last  = end_last.hit_idx[IDX_W-1:0];
            res_occ   = res_span[COUNT_W-1:0];
        end
        else
        begin
            res_first = '0;
            res_last  = '0;
            res_occ   = '0;
        end
    end

    assign out_take = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || out_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (done)
            begin
                busy_reg <= 1'b0;
            end

            if (done)
            begin
                if (out_free)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    pend_valid_reg <= 1'b1;
                end
            end
            else if (pend_valid_reg && out_free)
            begin
                pend_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            if (out_free)
            begin
                out_found_reg <= res_found;
                out_first_reg <= res_first;
                out_last_reg  <= res_last;
                out_occ_reg   <= res_occ;
            end
            else
            begin
                pend_found_reg <= res_found;
                pend_first_reg <= res_first;
                pend_last_reg  <= res_last;
                pend_occ_reg   <= res_occ;
            end
        end
        else if (pend_valid_reg && out_free)
        begin
            out_found_reg <= pend_found_reg;
            out_first_reg <= pend_first_reg;
            out_last_reg  <= pend_last_reg;
            out_occ_reg   <= pend_occ_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = out_found_reg;
    assign first_index = out_first_reg;
    assign last_index  = out_last_reg;
    assign occurrences = out_occ_reg;

endmodule
